// ===== rtl/core/psr_pkg.sv =====
// ----------------------------------------------------------------------------
// psr_pkg - shared types and constants of the polyphase sinc resampler
// Controller states, command and status groups, register map, opcodes and
// fixed phase-format constants.
// ----------------------------------------------------------------------------
package psr_pkg;

	localparam int TAP_SLOTS = 2048;
	localparam int TAP_BITS  = 11;
	localparam int FRAC_BITS = 10;
	localparam int FRAC_ONE  = 1024;
	localparam int PHASE_ACC_BITS = 18;

	localparam logic [15:0] RATIO_RESET  = 16'd22878;
	localparam logic [10:0] TAPS_RESET   = 11'd1475;
	localparam logic [4:0]  PHASES_RESET = 5'd13;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_COEF = 1'b1;

	localparam logic [1:0] REG_RATIO  = 2'd0;
	localparam logic [1:0] REG_TAPS   = 2'd1;
	localparam logic [1:0] REG_PHASES = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_INIT,
		ST_WALK1,
		ST_SECOND,
		ST_WALK2,
		ST_DIFF,
		ST_MUL,
		ST_SUM,
		ST_SAT,
		ST_FINISH
	} psr_state_t;

	typedef struct packed {
		logic push;
		logic coef_wr;
		logic walk_first;
		logic walk_second;
		logic walk_step;
		logic diff;
		logic mul;
		logic sum;
		logic sat;
	} psr_cmd_t;

	typedef struct packed {
		logic emit_due;
		logic walk_left;
		logic pipe_busy;
	} psr_stat_t;

endpackage

// ===== rtl/core/psr_ctrl.sv =====
// ----------------------------------------------------------------------------
// psr_ctrl - resampler sequencer
// Accepts words, runs the two tap walks and the interpolation steps, and
// hands the finished sample to the output register.
// ----------------------------------------------------------------------------
module psr_ctrl import psr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      operation,
	output logic      in_ready,
	input  logic      out_free,
	input  psr_stat_t stat,
	output psr_cmd_t  cmd,
	output logic      emit
);

	psr_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == OP_COEF) begin
						cmd.coef_wr = 1'b1;
					end else begin
						cmd.push = 1'b1;
						if (stat.emit_due) state_d = ST_INIT;
					end
				end
			end
			ST_INIT: begin
				cmd.walk_first = 1'b1;
				state_d = ST_WALK1;
			end
			ST_WALK1: begin
				if (stat.walk_left) cmd.walk_step = 1'b1;
				else if (!stat.pipe_busy) state_d = ST_SECOND;
			end
			ST_SECOND: begin
				cmd.walk_second = 1'b1;
				state_d = ST_WALK2;
			end
			ST_WALK2: begin
				if (stat.walk_left) cmd.walk_step = 1'b1;
				else if (!stat.pipe_busy) state_d = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) begin
					emit = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/psr_dp.sv =====
// ----------------------------------------------------------------------------
// psr_dp - resampler datapath
// Sample ring, coefficient store, phase accumulator, one MAC walked over the
// taps, and the interpolate / round / saturate steps.
// ----------------------------------------------------------------------------
module psr_dp import psr_pkg::*; #(
	parameter int RING_DEPTH  = 2048,
	parameter int MAX_PHASES  = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  psr_cmd_t                      cmd,
	output psr_stat_t                     stat,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [3:0]                    coef_phase,
	input  logic [TAP_BITS-1:0]           coef_tap,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	input  logic [15:0]                   clock_ratio,
	input  logic [TAP_BITS-1:0]           tap_count,
	input  logic [4:0]                    phase_count,
	output logic signed [SAMPLE_BITS-1:0] result
);

	localparam int RW     = $clog2(RING_DEPTH);
	localparam int FW     = $clog2(RING_DEPTH + 1);
	localparam int PCW    = $clog2(MAX_PHASES + 1);
	localparam int TW     = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;
	localparam int CDEPTH = MAX_PHASES * TAP_SLOTS;
	localparam int CAW    = $clog2(CDEPTH);
	localparam int PRW    = FRAC_BITS + PCW;
	localparam int PW     = SAMPLE_BITS + COEF_BITS;
	localparam int AW     = PW + TAP_BITS;
	localparam int DW     = AW + 1;
	localparam int OW     = DW + FRAC_BITS + 1;
	localparam int SW     = AW + 2;
	localparam int AB     = PHASE_ACC_BITS;

	localparam logic signed [SW-1:0] RND  = SW'(64'sd1 <<< (COEF_BITS - 2));
	localparam logic signed [SW-1:0] SMAX = SW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [SW-1:0] SMIN = SW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

	// ring, write pointer, fill count (unwritten entries read as zero)
	logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
	logic [RW-1:0]          wp_q, wp_m1, wp_m2, idx_q, idx_dec;
	logic [FW-1:0]          fill_q;
	logic [SAMPLE_BITS-1:0] ring_rd_s1;

	logic [COEF_BITS-1:0]   coef_mem [CDEPTH];
	logic [CAW-1:0]         coef_waddr, coef_raddr;
	logic                   coef_ok;
	logic [COEF_BITS-1:0]   coef_rd_s1;

	logic [AB-1:0]          phase_q;
	logic [15:0]            ratio_eff;
	logic [PCW-1:0]         pc_eff, first_w, second_w;
	logic [7:0]             pc_wide;
	logic [PRW-1:0]         prod;
	logic                   wrap;

	logic [TW-1:0]          first_q, second_q, table_q;
	logic                   wrap_q;
	logic [FRAC_BITS-1:0]   off_q;
	logic [TAP_BITS-1:0]    tap_q, rem_q;

	logic                   vld_s1, ok_s1, vld_s2;
	logic signed [SAMPLE_BITS-1:0] smp;
	logic signed [PW-1:0]   prod_s2;
	logic signed [AW-1:0]   mac_q, v1_q;
	logic signed [DW-1:0]   diff_q;
	logic signed [OW-1:0]   offp_q;
	logic signed [SW-1:0]   sum_q, shifted;
	logic signed [SAMPLE_BITS-1:0] res_q;

	function automatic logic [RW-1:0] ring_dec(input logic [RW-1:0] x);
		ring_dec = (x == '0) ? RW'(RING_DEPTH - 1) : x - 1'b1;
	endfunction

	assign wp_m1   = ring_dec(wp_q);
	assign wp_m2   = ring_dec(wp_m1);
	assign idx_dec = ring_dec(idx_q);

	// phase selection
	assign pc_wide = {3'b000, phase_count};
	always_comb begin
		if (phase_count == '0) pc_eff = PCW'(1);
		else if (pc_wide > 8'(MAX_PHASES)) pc_eff = PCW'(MAX_PHASES);
		else pc_eff = PCW'(phase_count);
	end
	assign prod      = PRW'(pc_eff) * PRW'(phase_q[FRAC_BITS-1:0]);
	assign first_w   = prod[PRW-1:FRAC_BITS];
	assign second_w  = first_w + 1'b1;
	assign wrap      = (second_w == pc_eff);
	assign ratio_eff = (clock_ratio < 16'(FRAC_ONE)) ? 16'(FRAC_ONE) : clock_ratio;

	assign stat.emit_due  = (phase_q < AB'(FRAC_ONE));
	assign stat.walk_left = (rem_q != '0);
	assign stat.pipe_busy = vld_s1 | vld_s2;

	// memories
	assign coef_waddr = CAW'({coef_phase, coef_tap});
	assign coef_raddr = CAW'({table_q, tap_q});
	assign coef_ok    = (8'(coef_phase) < 8'(MAX_PHASES));

	always_ff @(posedge clk) begin
		if (cmd.push) ring_mem[wp_q] <= sample_in;
		ring_rd_s1 <= ring_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.coef_wr && coef_ok) coef_mem[coef_waddr] <= coef_value;
		coef_rd_s1 <= coef_mem[coef_raddr];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			phase_q <= '0;
			rem_q   <= '0;
			vld_s1  <= 1'b0;
			ok_s1   <= 1'b0;
			vld_s2  <= 1'b0;
		end else begin
			if (cmd.push) begin
				wp_q <= (wp_q == RW'(RING_DEPTH - 1)) ? '0 : wp_q + 1'b1;
				if (fill_q != FW'(RING_DEPTH)) fill_q <= fill_q + 1'b1;
				if (stat.emit_due)
					phase_q <= phase_q + AB'(ratio_eff) - AB'(FRAC_ONE);
				else
					phase_q <= phase_q - AB'(FRAC_ONE);
			end
			if (cmd.walk_first || cmd.walk_second) rem_q <= tap_count;
			else if (cmd.walk_step) rem_q <= rem_q - 1'b1;
			vld_s1 <= cmd.walk_step;
			ok_s1  <= (fill_q == FW'(RING_DEPTH)) || (FW'(idx_q) < fill_q);
			vld_s2 <= vld_s1;
		end
	end

	// walk pointers and phase picks
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			first_q  <= TW'(first_w);
			second_q <= wrap ? '0 : TW'(second_w);
			wrap_q   <= wrap;
			off_q    <= prod[FRAC_BITS-1:0];
		end
		if (cmd.walk_first) begin
			idx_q   <= wp_m2;
			tap_q   <= tap_count - 1'b1;
			table_q <= first_q;
		end else if (cmd.walk_second) begin
			// second table wrapped to phase 0: window one sample later
			idx_q   <= wrap_q ? wp_m1 : wp_m2;
			tap_q   <= tap_count - 1'b1;
			table_q <= second_q;
		end else if (cmd.walk_step) begin
			idx_q <= idx_dec;
			tap_q <= tap_q - 1'b1;
		end
	end

	// MAC
	assign smp = ok_s1 ? $signed(ring_rd_s1) : '0;

	always_ff @(posedge clk) begin
		prod_s2 <= smp * $signed(coef_rd_s1);
		if (cmd.walk_first || cmd.walk_second) mac_q <= '0;
		else if (vld_s2) mac_q <= mac_q + AW'(prod_s2);
		if (cmd.walk_second) v1_q <= mac_q;
	end

	// interpolate, round, saturate
	assign shifted = sum_q >>> (COEF_BITS - 1);

	always_ff @(posedge clk) begin
		if (cmd.diff) diff_q <= DW'(mac_q) - DW'(v1_q);
		if (cmd.mul)  offp_q <= $signed({1'b0, off_q}) * diff_q;
		if (cmd.sum)  sum_q  <= SW'(v1_q) + SW'(offp_q >>> FRAC_BITS) + RND;
		if (cmd.sat) begin
			if (shifted > SMAX) res_q <= SMAX[SAMPLE_BITS-1:0];
			else if (shifted < SMIN) res_q <= SMIN[SAMPLE_BITS-1:0];
			else res_q <= shifted[SAMPLE_BITS-1:0];
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/core/polyphase_sinc_resampler.sv =====
// A push that emits runs the first tap walk, the second tap walk, then the
// difference, multiply, sum and saturate steps, plus any wait for the output
// register to free up. Other pushes and coefficient writes keep the idle state.
// Throughput is set by the single MAC walking both phase tables, one tap a cycle.
// Reset clears the controller, ring fill count, write pointer and phase
// accumulator at once; the coefficient store is undefined until written.
// ----------------------------------------------------------------------------
// polyphase_sinc_resampler - top level
// APB register file, output register and the controller / datapath pair.
// ----------------------------------------------------------------------------
module polyphase_sinc_resampler import psr_pkg::*; #(
	parameter int RING_DEPTH  = 2048,
	parameter int MAX_PHASES  = 16,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [3:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          operation,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [3:0]                    coef_phase,
	input  logic [TAP_BITS-1:0]           coef_tap,
	input  logic signed [COEF_BITS-1:0]   coef_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out
);

	logic [15:0]         ratio_q;
	logic [TAP_BITS-1:0] taps_q;
	logic [4:0]          phases_q;
	logic                wr_en;

	psr_cmd_t            cmd;
	psr_stat_t           stat;
	logic                emit, out_free, out_valid_q;
	logic signed [SAMPLE_BITS-1:0] result, out_q;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q  <= RATIO_RESET;
			taps_q   <= TAPS_RESET;
			phases_q <= PHASES_RESET;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_RATIO:  ratio_q  <= pwdata[15:0];
				REG_TAPS:   taps_q   <= pwdata[TAP_BITS-1:0];
				REG_PHASES: phases_q <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_RATIO:  prdata = {16'd0, ratio_q};
			REG_TAPS:   prdata = {21'd0, taps_q};
			REG_PHASES: prdata = {27'd0, phases_q};
			default:    prdata = '0;
		endcase
	end

	// output word register, decoupled from the next computation
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= result;
	end

	assign out_valid  = out_valid_q;
	assign sample_out = out_q;

	psr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.out_free  (out_free),
		.stat      (stat),
		.cmd       (cmd),
		.emit      (emit)
	);

	psr_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.MAX_PHASES  (MAX_PHASES),
		.SAMPLE_BITS (SAMPLE_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.sample_in   (sample_in),
		.coef_phase  (coef_phase),
		.coef_tap    (coef_tap),
		.coef_value  (coef_value),
		.clock_ratio (ratio_q),
		.tap_count   (taps_q),
		.phase_count (phases_q),
		.result      (result)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for polyphase_sinc_resampler
// Loads coefficient tables and pushes audio words through the block under
// several register settings. A bit-true fixed-point model in the bench
// predicts every output word. Both handshakes idle at random, and one long
// output stall backs the block up into its input.
// ----------------------------------------------------------------------------
module tb import psr_pkg::*; ();

	typedef struct {
		logic                op;
		logic signed [15:0]  smp;
		logic [3:0]          ph;
		logic [10:0]         tap;
		logic signed [17:0]  cval;
	} word_t;

	logic               clk;
	logic               arst_n;
	logic               psel, penable, pwrite, pready;
	logic [3:0]         paddr;
	logic [31:0]        pwdata, prdata;
	logic               in_valid, in_ready;
	logic               operation;
	logic signed [15:0] sample_in;
	logic [3:0]         coef_phase;
	logic [10:0]        coef_tap;
	logic signed [17:0] coef_value;
	logic               out_valid, out_ready;
	logic signed [15:0] sample_out;

	polyphase_sinc_resampler dut (.*);

	// bench copy of block state
	logic signed [15:0] pcm_ring [2048];
	logic signed [17:0] coef_mem [16][2048];
	bit                 coef_known [16][2048];
	int unsigned        wr_pos, phase_acc;
	int unsigned        ratio_reg, taps_reg, phases_reg;

	word_t              pend_q [$];
	logic signed [15:0] out_q [$];
	int                 errs;
	bit                 calm;
	int                 hold_ask, hold_done, hold_left, in_gap, out_gap;
	bit                 in_took;
	int                 idle_cnt;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (calm || r < 55) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(15, 70);
	endfunction

	function automatic longint tap_sum(int unsigned start, int unsigned tbl, int unsigned taps);
		longint acc;
		acc = 0;
		for (int unsigned j = 0; j < taps; j++)
			acc += longint'(pcm_ring[(start + j) % 2048]) * longint'(coef_mem[tbl][j]);
		return acc;
	endfunction

	function automatic logic signed [15:0] interp_out(int unsigned sub);
		int unsigned pc, taps, prod, first, second, off, start, start2;
		longint v1, v2, d, dh, dl, mix, o;
		pc = phases_reg;
		if (pc < 1) pc = 1;
		if (pc > 16) pc = 16;
		taps = taps_reg;
		prod = sub * pc;
		first = prod >> FRAC_BITS;
		off = prod & 32'h3ff;
		start = (wr_pos + 4096 - 1 - (taps % 2048)) % 2048;
		v1 = tap_sum(start, first, taps);
		second = first + 1;
		start2 = start;
		if (second == pc) begin
			second = 0;
			start2 = (start + 1) % 2048;
		end
		v2 = tap_sum(start2, second, taps);
		d = v2 - v1;
		dh = d >>> FRAC_BITS;
		dl = d - dh * FRAC_ONE;
		mix = v1 + longint'(off) * dh + ((longint'(off) * dl) >>> FRAC_BITS);
		o = (mix + (longint'(1) << 16)) >>> 17;
		if (o > 32767) o = 32767;
		if (o < -32768) o = -32768;
		return o[15:0];
	endfunction

	// apply one accepted word to the bench state
	task automatic step_word(word_t w);
		int unsigned r;
		if (w.op == OP_COEF) begin
			coef_mem[w.ph][w.tap] = w.cval;
			return;
		end
		pcm_ring[wr_pos] = w.smp;
		wr_pos = (wr_pos + 1) % 2048;
		r = (ratio_reg < FRAC_ONE) ? FRAC_ONE : ratio_reg;
		if (phase_acc < FRAC_ONE) begin
			out_q.push_back(interp_out(phase_acc));
			phase_acc += r;
		end
		phase_acc -= FRAC_ONE;
	endtask

	task automatic reg_write(logic [1:0] idx, int unsigned val);
		@(negedge clk);
		psel <= 1; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
		@(negedge clk);
		penable <= 1;
		@(negedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			REG_RATIO: ratio_reg = val & 32'hffff;
			REG_TAPS:  taps_reg = val & 32'h7ff;
			default:   phases_reg = val & 32'h1f;
		endcase
		idle_cnt = 0;
	endtask

	function automatic void add_coef(int ph, int tap, logic signed [17:0] v);
		word_t w;
		w.op = OP_COEF; w.smp = 16'($urandom); w.ph = 4'(ph); w.tap = 11'(tap);
		w.cval = v;
		coef_known[ph][tap] = 1;
		pend_q.push_back(w);
	endfunction

	function automatic void add_push(logic signed [15:0] s);
		word_t w;
		w.op = OP_PUSH; w.smp = s; w.ph = 4'($urandom); w.tap = 11'($urandom);
		w.cval = 18'($urandom);
		pend_q.push_back(w);
	endfunction

	function automatic logic signed [17:0] rand_coef();
		int r;
		r = $urandom_range(19);
		if (r == 0) return 18'sh1ffff;
		if (r == 1) return -18'sh20000;
		if (r < 10) return 18'($urandom);
		return $signed(18'($urandom_range(0, 4095))) - 18'sd2048;
	endfunction

	function automatic logic signed [15:0] rand_sample();
		int r;
		r = $urandom_range(19);
		if (r == 0) return 16'sh7fff;
		if (r == 1) return -16'sh8000;
		return 16'($urandom);
	endfunction

	// make sure every table entry the current setting reads has been loaded
	function automatic void fill_tables();
		int pc;
		pc = (phases_reg < 1) ? 1 : (phases_reg > 16) ? 16 : phases_reg;
		for (int p = 0; p < pc; p++)
			for (int t = 0; t < int'(taps_reg); t++)
				if (!coef_known[p][t]) add_coef(p, t, rand_coef());
	endfunction

	task automatic configure(int unsigned ratio, int unsigned taps, int unsigned pcount);
		reg_write(REG_RATIO, ratio);
		reg_write(REG_TAPS, taps);
		reg_write(REG_PHASES, pcount);
		fill_tables();
	endtask

	task automatic drain();
		while (pend_q.size() != 0 || in_valid || out_q.size() != 0) @(posedge clk);
		repeat (2 * taps_reg + 40) @(posedge clk);
	endtask

	task automatic random_pushes(int n);
		int pc;
		pc = (phases_reg < 1) ? 1 : (phases_reg > 16) ? 16 : phases_reg;
		for (int i = 0; i < n; i++) begin
			if (taps_reg != 0 && $urandom_range(9) < 2)
				add_coef($urandom_range(pc - 1), $urandom_range(taps_reg - 1), rand_coef());
			else
				add_push(rand_sample());
		end
	endtask

	// sender
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap <= 0;
		end else if (!in_valid || in_took) begin
			if (in_gap > 0) begin
				in_valid <= 0;
				in_gap <= in_gap - 1;
			end else if (pend_q.size() != 0) begin
				word_t w;
				w = pend_q.pop_front();
				in_valid <= 1;
				operation <= w.op; sample_in <= w.smp; coef_phase <= w.ph;
				coef_tap <= w.tap; coef_value <= w.cval;
				in_gap <= pick_gap();
			end else begin
				in_valid <= 0;
			end
		end
	end

	// receiver
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_ask != hold_done) begin
			hold_done <= hold_ask;
			hold_left <= 3000;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= 0;
		end else begin
			out_ready <= 1;
			out_gap <= pick_gap();
		end
	end

	// input acceptance and output check
	always @(posedge clk) begin
		in_took <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			word_t w;
			w.op = operation; w.smp = sample_in; w.ph = coef_phase;
			w.tap = coef_tap; w.cval = coef_value;
			step_word(w);
		end
		if (out_valid && out_ready) begin
			if (out_q.size() == 0) begin
				$error("unexpected output word sample_out=%0d", sample_out);
				errs++;
			end else begin
				logic signed [15:0] e;
				e = out_q.pop_front();
				if (sample_out !== e) begin
					$error("sample_out expected %0d actual %0d", e, sample_out);
					errs++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cnt = 0;
		else
			idle_cnt++;
		if (idle_cnt >= 30000) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		errs = 0; calm = 0; hold_ask = 0; idle_cnt = 0;
		wr_pos = 0; phase_acc = 0;
		ratio_reg = RATIO_RESET; taps_reg = TAPS_RESET; phases_reg = PHASES_RESET;
		foreach (pcm_ring[i]) pcm_ring[i] = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		operation = OP_PUSH; sample_in = 0; coef_phase = 0; coef_tap = 0; coef_value = 0;
		arst_n = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: field extremes with a single tap, one phase
		configure(1024, 1, 1);
		add_coef(0, 0, -18'sh20000);
		add_push(16'sh7fff); add_push(-16'sh8000); add_push(0); add_push(-1);
		add_coef(0, 0, 18'sh1ffff);
		add_push(16'sh7fff); add_push(-16'sh8000); add_push(1);
		add_coef(0, 0, 18'sh00001);
		add_push(16'sh7fff); add_push(-16'sh8000);
		drain();

		// zero taps, zero phase count, ratio below one input clock
		configure(0, 0, 0);
		repeat (5) add_push(rand_sample());
		drain();

		// phase count above store, ratio just under one clock
		configure(1000, 2, 31);
		random_pushes(15);
		drain();

		// long tap window, slowest output rate
		calm = 1;
		configure(65535, 120, 1);
		calm = 0;
		random_pushes(100);
		drain();

		// long output stall while the sender keeps offering
		configure(1024, 3, 4);
		random_pushes(40);
		hold_ask++;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			configure($urandom_range(1024, (ph % 2) ? 40000 : 4000),
				$urandom_range(1, 10), $urandom_range(1, 6));
			random_pushes(20);
			drain();
		end

		while (out_q.size() != 0) begin
			$error("sample_out expected %0d actual none", out_q.pop_front());
			errs++;
		end
		if (errs == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
